### hw/rtl/instance_norm_forward_macros.svh
// assertion macros for the instance norm block
`ifndef INSTANCE_NORM_FORWARD_MACROS_SVH
`define INSTANCE_NORM_FORWARD_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define INF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("instance norm check failed");

// next-cycle implication, disabled while reset is low
`define INF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("instance norm check failed");

`endif

### hw/rtl/inf_pkg.sv
// ----------------------------------------------------------------------------
// inf_pkg
// Shared constants, types and the sequencer states of the instance norm block.
// ----------------------------------------------------------------------------
package inf_pkg;

    localparam int MAX_SAMPLES = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = 7;
    localparam int EPS_W       = 32;
    localparam int CFG_IDX_W   = 4;
    localparam int ACC_W       = 48;
    localparam int DIV_W       = 40;
    localparam int DVS_W       = 24;
    localparam int INV_W       = 24;
    localparam int PROD_W      = 40;
    localparam int ROOT_W      = 21;
    localparam int SQRT_STEPS  = 20;
    localparam int SQ_CNT_W    = 5;
    localparam int OUT_W       = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EPSILON      = 4'd1;

    localparam logic [CNT_W-1:0] COUNT_RESET = 7'd64;
    localparam logic [EPS_W-1:0] EPS_RESET   = 32'd1;
    localparam logic [INV_W-1:0] INV_MAX     = {INV_W{1'b1}};

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SUM,
        ST_MEAN_DIV,
        ST_VAR,
        ST_VAR_DIV,
        ST_SQRT,
        ST_INV_DIV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

### hw/rtl/inf_if.sv
// ----------------------------------------------------------------------------
// inf_if
// Valid/ready channels of the instance norm block: samples, results, config.
// ----------------------------------------------------------------------------
interface inf_in_if import inf_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source(output valid, output sample, input ready);
    modport sink(input valid, input sample, output ready);
endinterface

interface inf_out_if import inf_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] normalized;
    logic [OUT_W-1:0]        std_dev;
    logic                    last_of_run;

    modport source(output valid, output normalized, output std_dev, output last_of_run,
                   input ready);
    modport sink(input valid, input normalized, input std_dev, input last_of_run,
                 output ready);
endinterface

interface inf_cfg_if import inf_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [EPS_W-1:0]     data;

    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

### hw/rtl/inf_divider.sv
// ----------------------------------------------------------------------------
// inf_divider
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// ----------------------------------------------------------------------------
module inf_divider import inf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int STEP_W = $clog2(DIV_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DIV_W-1:0]  r_quo;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic [DVS_W:0]    trial;
    logic              fits;

    // one trial subtraction
    always_comb begin
        trial = {r_rem, r_quo[DIV_W-1]};
        fits  = (trial >= {1'b0, r_dvs});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_W-2:0], fits};
            r_rem <= fits ? DVS_W'(trial - {1'b0, r_dvs}) : trial[DVS_W-1:0];
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

### hw/rtl/instance_norm_forward.sv
// Instance normalization, forward pass. The block loads S samples (S from
// sample_count, 2 to 64), then runs a sum pass, a mean division, a squared
// deviation pass, a variance division, a 20-step square root and a reciprocal
// division before it emits S results. Each pass walks every sample through a
// store read, a subtract (an add in the sum pass), a multiply and an
// accumulate or emit, and each division runs on the shared restoring divider.
// Input is not ready between the last sample of a segment and the last result
// of that segment.
// ----------------------------------------------------------------------------
// instance_norm_forward
// Top level: sample store, sequencer, multiplier, square root and output stage.
// ----------------------------------------------------------------------------
module instance_norm_forward import inf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    inf_in_if.sink      i_in,
    inf_out_if.source   o_out,
    inf_cfg_if.sink     i_cfg
);

    t_state r_state, n_state;
    logic   r_enter;

    logic [CNT_W-1:0] r_sample_count;
    logic [EPS_W-1:0] r_eps;
    logic [CNT_W-1:0] eff_s;
    logic [CNT_W-1:0] r_load;
    logic [CNT_W-1:0] wr_idx;

    logic [SAMPLE_BITS-1:0] r_mem [MAX_SAMPLES];
    logic [SAMPLE_BITS-1:0] r_rd;

    logic [CNT_W-1:0]              r_idx;
    logic [1:0]                    r_ph;
    logic [ACC_W-1:0]              r_acc;
    logic signed [SAMPLE_BITS-1:0] r_mean;
    logic                          r_neg;
    logic [SAMPLE_BITS-1:0]        r_mag;
    logic [PROD_W-1:0]             r_prod;
    logic [DIV_W-1:0]              r_sq_rem;
    logic [DIV_W-1:0]              r_sq_root;
    logic [DIV_W-1:0]              r_sq_bit;
    logic [SQ_CNT_W-1:0]           r_sq_cnt;
    logic [INV_W-1:0]              r_inv;

    logic                    r_o_valid;
    logic signed [OUT_W-1:0] r_o_norm;
    logic [OUT_W-1:0]        r_o_std;
    logic                    r_o_last;

    logic in_acc, cfg_acc, load_done, last_idx, out_free, step_adv, emit_fire, in_pass;
    logic sq_last;
    logic [ROOT_W-1:0] std_val;
    logic [ACC_W-1:0]  sum_mag;
    logic signed [SAMPLE_BITS:0] dev;
    logic [SAMPLE_BITS:0]        dev_abs;
    logic [INV_W-1:0]  mult_b;
    logic [DIV_W-1:0]  sq_try;
    logic [PROD_W-1:0] rnd;
    logic [OUT_W-1:0]  sat_norm;
    logic [OUT_W-1:0]  sat_std;
    logic [DIV_W-1:0]  half_s;
    t_div_req          div_req;
    t_div_rsp          div_rsp;

    // shared divider
    inf_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    // effective count and write index
    always_comb begin
        if (r_sample_count < CNT_W'(2)) begin
            eff_s = CNT_W'(2);
        end else if (r_sample_count > CNT_W'(MAX_SAMPLES)) begin
            eff_s = CNT_W'(MAX_SAMPLES);
        end else begin
            eff_s = r_sample_count;
        end
        wr_idx = (r_load >= eff_s) ? '0 : r_load;
        half_s = DIV_W'(eff_s[CNT_W-1:1]);
    end

    // handshake and step conditions
    always_comb begin
        in_acc    = i_in.valid && i_in.ready;
        cfg_acc   = i_cfg.valid && i_cfg.ready;
        load_done = in_acc && ((wr_idx + 1'b1) == eff_s);
        last_idx  = (r_idx == (eff_s - 1'b1));
        out_free  = !r_o_valid || o_out.ready;
        in_pass   = (r_state == ST_SUM) || (r_state == ST_VAR) || (r_state == ST_EMIT);
        step_adv  = in_pass && (r_ph == 2'd3) && ((r_state != ST_EMIT) || out_free);
        emit_fire = (r_state == ST_EMIT) && (r_ph == 2'd3) && out_free;
        sq_last   = !r_enter && (r_sq_cnt == SQ_CNT_W'(SQRT_STEPS - 1));
        std_val   = r_sq_root[ROOT_W-1:0];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD:     if (load_done) n_state = ST_SUM;
            ST_SUM:      if (step_adv && last_idx) n_state = ST_MEAN_DIV;
            ST_MEAN_DIV: if (div_rsp.done) n_state = ST_VAR;
            ST_VAR:      if (step_adv && last_idx) n_state = ST_VAR_DIV;
            ST_VAR_DIV:  if (div_rsp.done) n_state = ST_SQRT;
            ST_SQRT:     if (sq_last) n_state = ST_INV_DIV;
            ST_INV_DIV: begin
                if ((r_enter && std_val == '0) || div_rsp.done) n_state = ST_EMIT;
            end
            ST_EMIT:     if (step_adv && last_idx) n_state = ST_LOAD;
            default:     n_state = ST_LOAD;
        endcase
    end

    // outputs of the sequencer: ready and divider requests
    always_comb begin
        sum_mag          = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : r_acc;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = DVS_W'(eff_s);
        case (r_state)
            ST_MEAN_DIV: begin
                div_req.start    = r_enter;
                div_req.dividend = sum_mag[DIV_W-1:0] + half_s;
            end
            ST_VAR_DIV: begin
                div_req.start    = r_enter;
                div_req.dividend = r_acc[DIV_W-1:0] + half_s;
            end
            ST_INV_DIV: begin
                div_req.start    = r_enter && (std_val != '0);
                div_req.dividend = (DIV_W'(1) << 23) + DIV_W'(std_val[ROOT_W-1:1]);
                div_req.divisor  = DVS_W'(std_val);
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    assign i_in.ready  = (r_state == ST_LOAD);
    assign i_cfg.ready = 1'b1;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_LOAD;
            r_enter        <= 1'b0;
            r_sample_count <= COUNT_RESET;
            r_eps          <= EPS_RESET;
            r_load         <= '0;
            r_idx          <= '0;
            r_ph           <= '0;
            r_sq_cnt       <= '0;
            r_o_valid      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_enter <= (n_state != r_state);
            // config writes
            if (cfg_acc && i_cfg.index == REG_SAMPLE_COUNT) begin
                r_sample_count <= i_cfg.data[CNT_W-1:0];
                r_load         <= '0;
            end else if (in_acc) begin
                r_load <= load_done ? '0 : wr_idx + 1'b1;
            end
            if (cfg_acc && i_cfg.index == REG_EPSILON) begin
                r_eps <= i_cfg.data;
            end
            // per-sample phase counter
            if (in_pass) begin
                if (step_adv) begin
                    r_ph  <= '0;
                    r_idx <= last_idx ? '0 : r_idx + 1'b1;
                end else if (r_ph != 2'd3) begin
                    r_ph <= r_ph + 1'b1;
                end
            end
            // square root step count
            if (r_state == ST_SQRT) begin
                r_sq_cnt <= r_enter ? '0 : r_sq_cnt + 1'b1;
            end
            // output register
            if (emit_fire) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // sample store
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mem[wr_idx[ADDR_W-1:0]] <= i_in.sample;
        end
        r_rd <= r_mem[r_idx[ADDR_W-1:0]];
    end

    // deviation, multiplier operand, square root trial, rounding
    always_comb begin
        dev      = $signed({r_rd[SAMPLE_BITS-1], r_rd}) - $signed({r_mean[SAMPLE_BITS-1], r_mean});
        dev_abs  = dev[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-dev) : dev;
        mult_b   = (r_state == ST_VAR) ? INV_W'(r_mag) : r_inv;
        sq_try   = r_sq_root + r_sq_bit;
        rnd      = (r_prod + PROD_W'(2048)) >> 12;
        if (r_neg) begin
            sat_norm = (rnd > PROD_W'(32768)) ? 16'h8000 : OUT_W'(-rnd);
        end else begin
            sat_norm = (rnd > PROD_W'(32767)) ? 16'h7fff : rnd[OUT_W-1:0];
        end
        sat_std = (std_val > ROOT_W'(16'hffff)) ? 16'hffff : std_val[OUT_W-1:0];
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (load_done) begin
            r_acc <= '0;
        end
        // passes over the store
        if (in_pass && r_ph == 2'd1) begin
            if (r_state == ST_SUM) begin
                r_acc <= r_acc + ACC_W'($signed(r_rd));
            end else begin
                r_neg <= dev[SAMPLE_BITS];
                r_mag <= dev_abs[SAMPLE_BITS-1:0];
            end
        end
        if (in_pass && r_ph == 2'd2) begin
            r_prod <= PROD_W'(r_mag) * PROD_W'(mult_b);
        end
        if (r_state == ST_VAR && r_ph == 2'd3) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        // mean from the divider
        if (r_state == ST_MEAN_DIV && div_rsp.done) begin
            r_mean <= r_acc[ACC_W-1] ? SAMPLE_BITS'(-div_rsp.quotient)
                                     : div_rsp.quotient[SAMPLE_BITS-1:0];
            r_acc  <= '0;
        end
        // variance plus epsilon seeds the square root
        if (r_state == ST_VAR_DIV && div_rsp.done) begin
            r_sq_rem <= div_rsp.quotient + DIV_W'(r_eps);
        end
        // square root, two bits per step
        if (r_state == ST_SQRT) begin
            if (r_enter) begin
                r_sq_root <= '0;
                r_sq_bit  <= DIV_W'(1) << 38;
            end else begin
                if (r_sq_rem >= sq_try) begin
                    r_sq_rem  <= r_sq_rem - sq_try;
                    r_sq_root <= (r_sq_root >> 1) + r_sq_bit;
                end else begin
                    r_sq_root <= r_sq_root >> 1;
                end
                r_sq_bit <= r_sq_bit >> 2;
            end
        end
        // reciprocal of std
        if (r_state == ST_INV_DIV) begin
            if (r_enter && std_val == '0) begin
                r_inv <= INV_MAX;
            end else if (div_rsp.done) begin
                r_inv <= div_rsp.quotient[INV_W-1:0];
            end
        end
        // result register
        if (emit_fire) begin
            r_o_norm <= sat_norm;
            r_o_std  <= sat_std;
            r_o_last <= last_idx;
        end
    end

    assign o_out.valid       = r_o_valid;
    assign o_out.normalized  = r_o_norm;
    assign o_out.std_dev     = r_o_std;
    assign o_out.last_of_run = r_o_last;

endmodule

### hw/rtl/inf_checker.sv
// ----------------------------------------------------------------------------
// inf_checker
// Port-level checks of the instance norm block, bound to the top level.
// ----------------------------------------------------------------------------
`include "instance_norm_forward_macros.svh"

module inf_checker import inf_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_ready,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic signed [OUT_W-1:0] i_out_normalized,
    input logic [OUT_W-1:0]        i_out_std_dev,
    input logic                    i_out_last,
    input logic                    i_cfg_ready
);

    // a stalled result holds its payload
    `INF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_normalized) && $stable(i_out_std_dev) && $stable(i_out_last))

    // a pending result that is not the last one means the run is still going
    `INF_ASSERT_IMPLY(a_busy_in_run, i_clk, i_rst_n, i_out_valid && !i_out_last, !i_in_ready)

    // configuration port never stalls
    `INF_ASSERT_IMPLY(a_cfg_ready, i_clk, i_rst_n, 1'b1, i_cfg_ready)

endmodule

bind instance_norm_forward inf_checker u_inf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_normalized(o_out.normalized),
    .i_out_std_dev   (o_out.std_dev),
    .i_out_last      (o_out.last_of_run),
    .i_cfg_ready     (i_cfg.ready)
);
